// ----- design/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assertion macros
// shared property macros for the hex to five tets unit, removable with ASSERT_OFF
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// same-cycle implication
`define ASSERT_IMPLY(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed: implication");

// next-cycle implication
`define ASSERT_NEXT(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed: next cycle");

`else

`define ASSERT_IMPLY(name, clk, rst_n, ante, cons)
`define ASSERT_NEXT(name, clk, rst_n, ante, cons)

`endif

`endif

// ----- design/lhft_pkg.sv -----
// ----------------------------------------------------------------------------
// lhft_pkg
// constants, types and split tables of the hex to five tets unit
// ----------------------------------------------------------------------------
`default_nettype none

package lhft_pkg;

	localparam int INDEX_BITS_DEF = 30;
	localparam int ROW_W          = 16;
	localparam int LAYER_W        = 30;
	localparam int NODE_W         = 30;
	localparam int CORNERS        = 8;
	localparam int CORNER_SEL_W   = 3;
	localparam int TETS           = 5;
	localparam int TET_NUM_W      = 3;
	localparam int GAP_W          = 3;
	localparam int DATA_W         = 32;
	localparam int ADDR_W         = 3;
	localparam int REG_IDX_W      = 1;

	localparam logic [TET_NUM_W-1:0] FIRST_TET = 3'd0;
	localparam logic [TET_NUM_W-1:0] LAST_TET  = 3'd4;

	// register map, index = paddr / 4
	localparam logic [REG_IDX_W-1:0] REG_CELLS_PER_ROW   = 1'b0;
	localparam logic [REG_IDX_W-1:0] REG_CELLS_PER_LAYER = 1'b1;

	localparam logic [ROW_W-1:0]   ROW_RESET   = 16'd1;
	localparam logic [LAYER_W-1:0] LAYER_RESET = 30'd1;

	// control that travels with a dividend through the divider stages
	typedef struct packed {
		logic valid;
		logic par;
	} div_ctl_t;

	localparam logic [CORNER_SEL_W-1:0] SPLIT_EVEN [TETS][4] = '{
		'{3'd0, 3'd1, 3'd2, 3'd5},
		'{3'd0, 3'd2, 3'd3, 3'd7},
		'{3'd0, 3'd5, 3'd2, 3'd7},
		'{3'd0, 3'd5, 3'd7, 3'd4},
		'{3'd5, 3'd2, 3'd7, 3'd6}
	};

	localparam logic [CORNER_SEL_W-1:0] SPLIT_ODD [TETS][4] = '{
		'{3'd0, 3'd1, 3'd3, 3'd4},
		'{3'd1, 3'd2, 3'd3, 3'd6},
		'{3'd1, 3'd3, 3'd4, 3'd6},
		'{3'd1, 3'd5, 3'd6, 3'd4},
		'{3'd3, 3'd4, 3'd6, 3'd7}
	};

	function automatic logic [CORNER_SEL_W-1:0] corner_sel(input logic odd,
			input logic [TET_NUM_W-1:0] tet, input logic [1:0] pos);
		logic [CORNER_SEL_W-1:0] sel;
		if (odd) begin
			sel = SPLIT_ODD[tet][pos];
		end else begin
			sel = SPLIT_EVEN[tet][pos];
		end
		return sel;
	endfunction

endpackage

`default_nettype wire

// ----- design/lhft_div_pipe.sv -----
// ----------------------------------------------------------------------------
// lhft_div_pipe
// restoring divider, one quotient bit per register stage; gives the remainder
// and folds quotient bit 0 into the parity carried alongside
// ----------------------------------------------------------------------------
`default_nettype none

module lhft_div_pipe #(
	parameter int NUM_W = lhft_pkg::INDEX_BITS_DEF,
	parameter int DEN_W = lhft_pkg::LAYER_W
) (
	input  logic               clk,
	input  logic               arst_n,
	input  lhft_pkg::div_ctl_t in_ctl,
	input  logic [NUM_W-1:0]   in_num,
	input  logic [DEN_W-1:0]   den,
	output lhft_pkg::div_ctl_t out_ctl,
	output logic [NUM_W-1:0]   out_rem
);
	import lhft_pkg::*;

	localparam int CMP_W = (NUM_W > DEN_W ? NUM_W : DEN_W) + 1;

	div_ctl_t         ctl_s [NUM_W];
	logic [NUM_W-1:0] rem_s [NUM_W];
	logic [NUM_W-1:0] num_s [NUM_W-1];

	for (genvar s = 0; s < NUM_W; s++) begin : g_stage
		div_ctl_t         ctl_in;
		logic [NUM_W-1:0] num_in;
		logic [NUM_W-1:0] rem_in;
		logic [NUM_W-1:0] rem_sh;
		logic [CMP_W-1:0] diff;
		logic             ge;

		if (s == 0) begin : g_first
			assign ctl_in = in_ctl;
			assign num_in = in_num;
			assign rem_in = '0;
		end else begin : g_next
			assign ctl_in = ctl_s[s-1];
			assign num_in = num_s[s-1];
			assign rem_in = rem_s[s-1];
		end

		// partial remainder never exceeds the dividend prefix, so no bit is lost
		assign rem_sh = {rem_in[NUM_W-2:0], num_in[NUM_W-1]};
		assign diff   = CMP_W'(rem_sh) - CMP_W'(den);
		assign ge     = ~diff[CMP_W-1];

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				ctl_s[s] <= '0;
			end else begin
				ctl_s[s].valid <= ctl_in.valid;
				if (s == NUM_W - 1) begin
					ctl_s[s].par <= ctl_in.par ^ ge;
				end else begin
					ctl_s[s].par <= ctl_in.par;
				end
			end
		end

		always_ff @(posedge clk) begin
			rem_s[s] <= ge ? diff[NUM_W-1:0] : rem_sh;
		end

		if (s < NUM_W - 1) begin : g_num
			always_ff @(posedge clk) begin
				num_s[s] <= {num_in[NUM_W-2:0], 1'b0};
			end
		end
	end

	assign out_ctl = ctl_s[NUM_W-1];
	assign out_rem = rem_s[NUM_W-1];

endmodule

`default_nettype wire

// ----- design/lattice_hex_to_five_tets_unit.sv -----
// ----------------------------------------------------------------------------
// lattice_hex_to_five_tets_unit
// splits a lattice hex cell into five tetrahedra, mirrored on odd i^j^k parity
// ----------------------------------------------------------------------------
//
// channel   | direction | handshake                        | payload
// ----------+-----------+----------------------------------+--------------------------
// cell in   | in        | start, accepted when busy is low | cell_index, corner0..7
// tet out   | out       | strobe, high with each result    | tet_node_a..d, tet_number,
//           |           |                                  | odd_cell, last_tet
// config    | in/out    | apb, pready tied high            | cells_per_row, cells_per_layer
//
// the cell rate is set by the output port emitting one tetrahedron a cycle
// two divider pipelines of INDEX_BITS stages each, then the emitter and output
// registers; the five results of a cell come on consecutive cycles
// busy stays high after each transaction until the gap counter runs out; several
// cells are in the divider at once, their corners wait in a small fifo
// reset clears valid bits and control, config registers return to 1

`default_nettype none
`include "assert_macros.svh"

module lattice_hex_to_five_tets_unit #(
	parameter int INDEX_BITS = lhft_pkg::INDEX_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	// cell in
	input  logic                               start,
	output logic                               busy,
	input  logic [INDEX_BITS-1:0]              cell_index,
	input  logic [INDEX_BITS-1:0]              corner0,
	input  logic [INDEX_BITS-1:0]              corner1,
	input  logic [INDEX_BITS-1:0]              corner2,
	input  logic [INDEX_BITS-1:0]              corner3,
	input  logic [INDEX_BITS-1:0]              corner4,
	input  logic [INDEX_BITS-1:0]              corner5,
	input  logic [INDEX_BITS-1:0]              corner6,
	input  logic [INDEX_BITS-1:0]              corner7,
	// tet out
	output logic                               strobe,
	output logic [lhft_pkg::NODE_W-1:0]        tet_node_a,
	output logic [lhft_pkg::NODE_W-1:0]        tet_node_b,
	output logic [lhft_pkg::NODE_W-1:0]        tet_node_c,
	output logic [lhft_pkg::NODE_W-1:0]        tet_node_d,
	output logic [lhft_pkg::TET_NUM_W-1:0]     tet_number,
	output logic                               odd_cell,
	output logic                               last_tet,
	// config
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [lhft_pkg::ADDR_W-1:0]        paddr,
	input  logic [lhft_pkg::DATA_W-1:0]        pwdata,
	output logic [lhft_pkg::DATA_W-1:0]        prdata,
	output logic                               pready
);
	import lhft_pkg::*;

	localparam int FIFO_AW    = $clog2((2 * INDEX_BITS + TETS) / TETS + 2);
	localparam int FIFO_DEPTH = 1 << FIFO_AW;

	// config registers
	logic [ROW_W-1:0]     cpr_q;
	logic [LAYER_W-1:0]   cpl_q;
	logic                 cfg_wr;
	logic [REG_IDX_W-1:0] reg_idx;

	// input side
	logic                 accept;
	logic [GAP_W-1:0]     gap_q;

	// corner fifo
	logic [CORNERS-1:0][INDEX_BITS-1:0] corner_mem [FIFO_DEPTH];
	logic [FIFO_AW-1:0]                 wr_ptr_q;
	logic [FIFO_AW-1:0]                 rd_ptr_q;
	logic [FIFO_AW-1:0]                 rd_next;
	logic [FIFO_AW-1:0]                 fifo_used;
	logic [CORNERS-1:0][INDEX_BITS-1:0] head_q;

	// dividers
	div_ctl_t              div1_in;
	div_ctl_t              div1_out;
	logic [INDEX_BITS-1:0] rem1;
	div_ctl_t              div2_out;
	logic [INDEX_BITS-1:0] rem2;

	// emitter
	logic                  emit_act_q;
	logic [TET_NUM_W-1:0]  tet_q;
	logic                  odd_q;
	logic                  emit_done;

	assign pready  = 1'b1;
	assign cfg_wr  = psel & penable & pwrite & pready;
	assign reg_idx = paddr[ADDR_W-1:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cpr_q <= ROW_RESET;
			cpl_q <= LAYER_RESET;
		end else if (cfg_wr) begin
			unique case (reg_idx)
				REG_CELLS_PER_ROW:   cpr_q <= pwdata[ROW_W-1:0];
				REG_CELLS_PER_LAYER: cpl_q <= pwdata[LAYER_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_CELLS_PER_ROW:   prdata = DATA_W'(cpr_q);
			REG_CELLS_PER_LAYER: prdata = DATA_W'(cpl_q);
			default:             prdata = '0;
		endcase
	end

	// the gap counter spaces transactions so the output port does not overrun
	assign accept = start & ~busy;
	assign busy   = (gap_q != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gap_q <= '0;
		end else if (accept) begin
			gap_q <= GAP_W'(TETS - 1);
		end else if (gap_q != '0) begin
			gap_q <= gap_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			corner_mem[wr_ptr_q] <= {corner7, corner6, corner5, corner4,
				corner3, corner2, corner1, corner0};
		end
	end

	// read one entry ahead when the head cell finishes, so the next cell
	// finds its corners ready on its first tetrahedron
	assign rd_next = rd_ptr_q + FIFO_AW'(emit_done);

	always_ff @(posedge clk) begin
		head_q <= corner_mem[rd_next];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
		end else begin
			if (accept) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (emit_done) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
		end
	end

	assign fifo_used = wr_ptr_q - rd_ptr_q;

	// k = index / cells_per_layer, then j, i from the remainder by cells_per_row
	assign div1_in = '{valid: accept, par: 1'b0};

	lhft_div_pipe #(
		.NUM_W (INDEX_BITS),
		.DEN_W (LAYER_W)
	) u_div_layer (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_ctl  (div1_in),
		.in_num  (cell_index),
		.den     (cpl_q),
		.out_ctl (div1_out),
		.out_rem (rem1)
	);

	lhft_div_pipe #(
		.NUM_W (INDEX_BITS),
		.DEN_W (ROW_W)
	) u_div_row (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_ctl  (div1_out),
		.in_num  (rem1),
		.den     (cpr_q),
		.out_ctl (div2_out),
		.out_rem (rem2)
	);

	assign emit_done = emit_act_q & (tet_q == LAST_TET);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			emit_act_q <= 1'b0;
			tet_q      <= FIRST_TET;
			odd_q      <= 1'b0;
		end else if (div2_out.valid) begin
			emit_act_q <= 1'b1;
			tet_q      <= FIRST_TET;
			// parity of k ^ j carried through, i bit 0 added here
			odd_q      <= div2_out.par ^ rem2[0];
		end else if (emit_act_q) begin
			if (emit_done) begin
				emit_act_q <= 1'b0;
			end else begin
				tet_q <= tet_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe <= 1'b0;
		end else begin
			strobe <= emit_act_q;
		end
	end

	always_ff @(posedge clk) begin
		tet_node_a <= NODE_W'(head_q[corner_sel(odd_q, tet_q, 2'd0)]);
		tet_node_b <= NODE_W'(head_q[corner_sel(odd_q, tet_q, 2'd1)]);
		tet_node_c <= NODE_W'(head_q[corner_sel(odd_q, tet_q, 2'd2)]);
		tet_node_d <= NODE_W'(head_q[corner_sel(odd_q, tet_q, 2'd3)]);
		tet_number <= tet_q;
		odd_cell   <= odd_q;
		last_tet   <= (tet_q == LAST_TET);
	end

	`ASSERT_NEXT(a_busy_after_accept, clk, arst_n, accept, busy)
	`ASSERT_NEXT(a_tets_contiguous, clk, arst_n, strobe && (tet_number != LAST_TET), strobe)
	`ASSERT_IMPLY(a_cell_spacing, clk, arst_n, div2_out.valid, !emit_act_q || emit_done)
	`ASSERT_IMPLY(a_fifo_room, clk, arst_n, accept, fifo_used != FIFO_AW'(FIFO_DEPTH - 1))

endmodule

`default_nettype wire

// ----- bench/tb_lattice_hex_to_five_tets_unit.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_lattice_hex_to_five_tets_unit
// self-checking bench for the hex to five tets unit: a directed table of cells
// under fixed lattice settings, then random cells over several settings, every
// tetrahedron compared field by field against an in-bench split predictor
// ----------------------------------------------------------------------------

module tb_lattice_hex_to_five_tets_unit;

	import lhft_pkg::*;

	localparam int          IW         = INDEX_BITS_DEF;
	localparam int          LATENCY    = 2 * IW + 1;
	localparam int          CYCLE_LIMIT = 200000;
	localparam int          DIR_ROWS   = 23;
	localparam int          PHASES     = 6;
	localparam int          PHASE_CELLS = 18;
	localparam logic [29:0] IDX_MASK   = 30'h3FFF_FFFF;
	localparam logic [1:0]  PRED_ODD   = 2'd2;

	localparam logic [2:0] EVEN_SPLIT [TETS][4] = '{
		'{3'd0, 3'd1, 3'd2, 3'd5},
		'{3'd0, 3'd2, 3'd3, 3'd7},
		'{3'd0, 3'd5, 3'd2, 3'd7},
		'{3'd0, 3'd5, 3'd7, 3'd4},
		'{3'd5, 3'd2, 3'd7, 3'd6}
	};

	localparam logic [2:0] ODD_SPLIT [TETS][4] = '{
		'{3'd0, 3'd1, 3'd3, 3'd4},
		'{3'd1, 3'd2, 3'd3, 3'd6},
		'{3'd1, 3'd3, 3'd4, 3'd6},
		'{3'd1, 3'd5, 3'd6, 3'd4},
		'{3'd3, 3'd4, 3'd6, 3'd7}
	};

	typedef struct packed {
		logic [29:0]       idx;
		logic [7:0][29:0]  corner;
	} cell_t;

	typedef struct packed {
		logic [29:0] a;
		logic [29:0] b;
		logic [29:0] c;
		logic [29:0] d;
		logic [2:0]  num;
		logic        odd;
		logic        last;
	} tet_t;

	// lattice setting, cell, corner base and step, parity (0, 1 or predicted)
	typedef struct packed {
		logic [15:0] row_cfg;
		logic [29:0] layer_cfg;
		logic [29:0] idx;
		logic [29:0] cbase;
		logic [29:0] cstep;
		logic [1:0]  odd_code;
	} dir_row_t;

	dir_row_t directed_rows [DIR_ROWS] = '{
		// reset setting: k is the index itself
		'{16'd1, 30'd1, 30'd0,           30'd0,           30'd1,           2'd0},
		'{16'd1, 30'd1, 30'd1,           30'd10,          30'd1,           2'd1},
		'{16'd1, 30'd1, 30'h3FFF_FFFF,   30'h3FFF_FFFF,   30'd0,           2'd1},
		'{16'd1, 30'd1, 30'h3FFF_FFFE,   30'd0,           30'd0,           2'd0},
		'{16'd1, 30'd1, 30'h2AAA_AAAA,   30'h1555_5555,   30'h1555_5555,   2'd0},
		'{16'd1, 30'd1, 30'h1555_5555,   30'h2AAA_AAAA,   30'h3FFF_FFFF,   2'd1},
		// 4 x 3 layer
		'{16'd4, 30'd12, 30'd0,          30'd1000,        30'd7,           PRED_ODD},
		'{16'd4, 30'd12, 30'd1,          30'd2000,        30'd9,           PRED_ODD},
		'{16'd4, 30'd12, 30'd4,          30'd3000,        30'd11,          PRED_ODD},
		'{16'd4, 30'd12, 30'd5,          30'd4000,        30'd13,          PRED_ODD},
		'{16'd4, 30'd12, 30'd12,         30'd5000,        30'd15,          PRED_ODD},
		'{16'd4, 30'd12, 30'd23,         30'd6000,        30'd17,          PRED_ODD},
		// largest divisors
		'{16'hFFFF, 30'h3FFF_FFFF, 30'd0,         30'h0FFF_FFF0, 30'd3,    2'd0},
		'{16'hFFFF, 30'h3FFF_FFFF, 30'h3FFF_FFFF, 30'h3FFF_FFF8, 30'd1,    2'd1},
		'{16'hFFFF, 30'h3FFF_FFFF, 30'd65535,     30'd77,        30'd65536, 2'd1},
		'{16'hFFFF, 30'h3FFF_FFFF, 30'd65534,     30'd5,         30'd5,    2'd0},
		// zero divisors: quotient all ones, remainder the dividend
		'{16'd0, 30'd0, 30'd6,           30'd40,          30'd2,           2'd0},
		'{16'd0, 30'd0, 30'd7,           30'd50,          30'd3,           2'd1},
		'{16'd0, 30'd0, 30'h3FFF_FFFF,   30'h2000_0000,   30'd1,           2'd1},
		'{16'd0, 30'd10, 30'd23,         30'd123,         30'd4,           PRED_ODD},
		'{16'd0, 30'd10, 30'd10,         30'd321,         30'd6,           PRED_ODD},
		'{16'd7, 30'd0, 30'd0,           30'd999,         30'd8,           PRED_ODD},
		'{16'd7, 30'd0, 30'd50,          30'd888,         30'd10,          PRED_ODD}
	};

	logic                   clk;
	logic                   arst_n     = 1'b0;
	logic                   start      = 1'b0;
	logic                   busy;
	logic [IW-1:0]          cell_index = '0;
	logic [IW-1:0]          corner0    = '0;
	logic [IW-1:0]          corner1    = '0;
	logic [IW-1:0]          corner2    = '0;
	logic [IW-1:0]          corner3    = '0;
	logic [IW-1:0]          corner4    = '0;
	logic [IW-1:0]          corner5    = '0;
	logic [IW-1:0]          corner6    = '0;
	logic [IW-1:0]          corner7    = '0;
	logic                   strobe;
	logic [NODE_W-1:0]      tet_node_a;
	logic [NODE_W-1:0]      tet_node_b;
	logic [NODE_W-1:0]      tet_node_c;
	logic [NODE_W-1:0]      tet_node_d;
	logic [TET_NUM_W-1:0]   tet_number;
	logic                   odd_cell;
	logic                   last_tet;
	logic                   psel       = 1'b0;
	logic                   penable    = 1'b0;
	logic                   pwrite     = 1'b0;
	logic [ADDR_W-1:0]      paddr      = '0;
	logic [DATA_W-1:0]      pwdata     = '0;
	logic [DATA_W-1:0]      prdata;
	logic                   pready;

	// bench copy of the lattice setting
	logic [15:0]            row_len    = 16'd1;
	logic [29:0]            layer_len  = 30'd1;

	tet_t                   pending_tets [$];
	int                     mismatch_count = 0;
	int                     cycle_count    = 0;

	lattice_hex_to_five_tets_unit u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.cell_index (cell_index),
		.corner0    (corner0),
		.corner1    (corner1),
		.corner2    (corner2),
		.corner3    (corner3),
		.corner4    (corner4),
		.corner5    (corner5),
		.corner6    (corner6),
		.corner7    (corner7),
		.strobe     (strobe),
		.tet_node_a (tet_node_a),
		.tet_node_b (tet_node_b),
		.tet_node_c (tet_node_c),
		.tet_node_d (tet_node_d),
		.tet_number (tet_number),
		.odd_cell   (odd_cell),
		.last_tet   (last_tet),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("CHECKS FAILED");
			$finish;
		end
	end

	task automatic flag_field(input string what, input logic [31:0] got,
			input logic [31:0] want);
		if (got !== want) begin
			$display("mismatch %s: got %0h expected %0h", what, got, want);
			mismatch_count++;
		end
	endtask

	// parity of i ^ j ^ k; a zero divisor gives an all-ones quotient
	function automatic logic cell_split_parity(input logic [29:0] idx);
		logic [31:0] k, rem, j, i;
		if (layer_len == '0) begin
			k   = '1;
			rem = {2'b00, idx};
		end else begin
			k   = {2'b00, idx} / {2'b00, layer_len};
			rem = {2'b00, idx} % {2'b00, layer_len};
		end
		if (row_len == '0) begin
			j = '1;
			i = rem;
		end else begin
			j = rem / {16'd0, row_len};
			i = rem % {16'd0, row_len};
		end
		return k[0] ^ j[0] ^ i[0];
	endfunction

	function automatic void queue_cell_tets(input cell_t cl, input logic odd);
		tet_t t;
		logic [2:0] sel [4];
		for (int n = 0; n < TETS; n++) begin
			for (int p = 0; p < 4; p++) begin
				sel[p] = odd ? ODD_SPLIT[n][p] : EVEN_SPLIT[n][p];
			end
			t.a    = cl.corner[sel[0]];
			t.b    = cl.corner[sel[1]];
			t.c    = cl.corner[sel[2]];
			t.d    = cl.corner[sel[3]];
			t.num  = 3'(n);
			t.odd  = odd;
			t.last = (n == TETS - 1);
			pending_tets = {pending_tets, t};
		end
	endfunction

	always @(posedge clk) begin : tet_monitor
		tet_t want;
		if (arst_n && strobe) begin
			if (pending_tets.size() == 0) begin
				flag_field("tet with nothing pending", 32'd1, 32'd0);
			end else begin
				want = pending_tets.pop_front();
				flag_field("tet_node_a", {2'b00, tet_node_a}, {2'b00, want.a});
				flag_field("tet_node_b", {2'b00, tet_node_b}, {2'b00, want.b});
				flag_field("tet_node_c", {2'b00, tet_node_c}, {2'b00, want.c});
				flag_field("tet_node_d", {2'b00, tet_node_d}, {2'b00, want.d});
				flag_field("tet_number", {29'd0, tet_number}, {29'd0, want.num});
				flag_field("odd_cell", {31'd0, odd_cell}, {31'd0, want.odd});
				flag_field("last_tet", {31'd0, last_tet}, {31'd0, want.last});
			end
		end
	end

	// start stays high after acceptance; the caller lowers it or sends again
	task automatic send_cell(input cell_t cl, input logic [1:0] odd_code);
		logic odd;
		start      <= 1'b1;
		cell_index <= cl.idx;
		corner0    <= cl.corner[0];
		corner1    <= cl.corner[1];
		corner2    <= cl.corner[2];
		corner3    <= cl.corner[3];
		corner4    <= cl.corner[4];
		corner5    <= cl.corner[5];
		corner6    <= cl.corner[6];
		corner7    <= cl.corner[7];
		do @(posedge clk); while (busy);
		odd = (odd_code == PRED_ODD) ? cell_split_parity(cl.idx) : odd_code[0];
		queue_cell_tets(cl, odd);
	endtask

	task automatic hold_off(input int cycles);
		if (cycles > 0) begin
			start <= 1'b0;
			repeat (cycles) @(posedge clk);
		end
	endtask

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 90) return $urandom_range(1, 4);
		return $urandom_range(15, 60);
	endfunction

	task automatic wait_idle();
		start <= 1'b0;
		do @(posedge clk); while (pending_tets.size() != 0 || busy);
		repeat (4) @(posedge clk);
	endtask

	task automatic apb_write(input logic [REG_IDX_W-1:0] regsel, input logic [31:0] data);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {regsel, 2'b00};
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic apb_read_check(input logic [REG_IDX_W-1:0] regsel, input string what,
			input logic [31:0] want);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= {regsel, 2'b00};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		flag_field(what, prdata, want);
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	// upper data bits carry junk, the register keeps only its own width
	task automatic set_lattice(input logic [15:0] r, input logic [29:0] l);
		logic [31:0] row_word, layer_word;
		row_word   = ($urandom & 32'hFFFF_0000) | {16'd0, r};
		layer_word = ($urandom & 32'hC000_0000) | {2'b00, l};
		wait_idle();
		if ($urandom_range(0, 1) == 1) begin
			apb_write(REG_CELLS_PER_ROW, row_word);
			apb_write(REG_CELLS_PER_LAYER, layer_word);
		end else begin
			apb_write(REG_CELLS_PER_LAYER, layer_word);
			apb_write(REG_CELLS_PER_ROW, row_word);
		end
		row_len   = r;
		layer_len = l;
		apb_read_check(REG_CELLS_PER_ROW, "cells_per_row readback", {16'd0, r});
		apb_read_check(REG_CELLS_PER_LAYER, "cells_per_layer readback", {2'b00, l});
	endtask

	initial begin : stimulus
		cell_t             cl;
		dir_row_t          dr;
		logic [15:0]       r;
		logic [29:0]       l;
		longint unsigned   top;
		int                mode;
		bit                no_gaps;

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		repeat (3) @(posedge clk);

		for (int n = 0; n < DIR_ROWS; n++) begin
			dr = directed_rows[n];
			if (dr.row_cfg != row_len || dr.layer_cfg != layer_len) begin
				set_lattice(dr.row_cfg, dr.layer_cfg);
			end
			cl.idx = dr.idx;
			for (int c = 0; c < 8; c++) begin
				cl.corner[c] = dr.cbase + 30'(c) * dr.cstep;
			end
			send_cell(cl, dr.odd_code);
			hold_off(pick_gap());
		end

		for (int phase = 0; phase < PHASES; phase++) begin
			case (phase)
				1: begin
					r   = 16'd1;
					l   = 30'd1;
					top = IDX_MASK;
				end
				2: begin
					r   = 16'($urandom);
					l   = 30'($urandom);
					top = IDX_MASK;
				end
				3: begin
					r   = 16'($urandom_range(1, 300));
					l   = 30'(r * $urandom_range(1, 300));
					top = longint'(l) * $urandom_range(1, 50) - 1;
				end
				4: begin
					mode = $urandom_range(0, 2);
					r    = (mode == 1) ? 16'($urandom_range(1, 9)) : 16'd0;
					l    = (mode == 0) ? 30'($urandom_range(1, 90)) : 30'd0;
					top  = ($urandom_range(0, 1) == 1) ? IDX_MASK : 2000;
				end
				default: begin
					r   = 16'($urandom_range(1, 8));
					l   = 30'(r * $urandom_range(1, 8));
					top = longint'(l) * $urandom_range(1, 16) - 1;
				end
			endcase
			if (top > IDX_MASK) top = IDX_MASK;
			set_lattice(r, l);
			no_gaps = (phase == 2);
			for (int n = 0; n < PHASE_CELLS; n++) begin
				if ($urandom_range(0, 3) == 0) begin
					cl.idx = 30'($urandom);
				end else begin
					cl.idx = 30'($urandom_range(0, 32'(top)));
				end
				for (int c = 0; c < 8; c++) begin
					cl.corner[c] = 30'($urandom);
				end
				if ($urandom_range(0, 15) == 0) begin
					cl.corner = ($urandom_range(0, 1) == 1) ? '1 : '0;
				end
				send_cell(cl, PRED_ODD);
				// let the pipeline run dry before going on
				if ((phase == 0 || phase == 5) && n == PHASE_CELLS / 2) begin
					wait_idle();
				end else if (!no_gaps) begin
					hold_off(pick_gap());
				end
			end
		end

		wait_idle();
		repeat (LATENCY + 10) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule

// ----- filelist.f -----
+incdir+design
design/lhft_pkg.sv
design/lhft_div_pipe.sv
design/lattice_hex_to_five_tets_unit.sv
bench/tb_lattice_hex_to_five_tets_unit.sv
